@@ hdl/swept_box_impact_time_top_macros.svh @@
// ----------------------------------------------------------------------------
// Swept box impact time - assertion macros
// Clocked assertion shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef SWEPT_BOX_IMPACT_TIME_TOP_MACROS_SVH
`define SWEPT_BOX_IMPACT_TIME_TOP_MACROS_SVH

// Assertion on clk_i, off while rst_ni is low.
`define SBIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same, for a property that only applies to a valid output word.
`define SBIT_ASSERT_OUT(lbl, prop, msg) \
  `SBIT_ASSERT(lbl, out_valid_o |-> (prop), msg)

`endif

@@ hdl/sbit_pkg.sv @@
// ----------------------------------------------------------------------------
// Swept box impact time - package
// Default widths and face codes.
// ----------------------------------------------------------------------------
package sbit_pkg;

  localparam int CoordBits = 32;
  localparam int FracBits  = 16;
  localparam int NumCases  = 4;

  typedef enum logic [2:0] {
    FaceNone   = 3'd0,
    FaceRight  = 3'd1,
    FaceLeft   = 3'd2,
    FaceTop    = 3'd3,
    FaceBottom = 3'd4
  } face_e;

  // per case (a right, a left, a up, a down): touching faces of a and b
  localparam face_e CaseFaceA [NumCases] = '{FaceRight, FaceLeft, FaceTop, FaceBottom};
  localparam face_e CaseFaceB [NumCases] = '{FaceLeft, FaceRight, FaceBottom, FaceTop};

endpackage

@@ hdl/sbit_div.sv @@
// ----------------------------------------------------------------------------
// Swept box impact time - pipelined divider
// Restoring division of num * 2^F by den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sbit_div #(
  parameter int NW = 33,
  parameter int DW = 33,
  parameter int F  = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [NW-1:0]       num_i,
  input  logic [DW-1:0]       den_i,
  output logic [NW+F-1:0]     quo_o
);

  localparam int QW = NW + F;

  logic [QW-1:0] num_q [QW];
  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [DW-1:0] den_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [QW-1:0] num_in;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;

    if (k == 0) begin : g_first
      assign num_in = QW'(num_i) << F;
      assign rem_in = '0;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign num_in = num_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, num_in[QW-1]};
    assign ge    = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= num_in << 1;
        rem_q[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_q[k] <= {quo_in[QW-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

@@ hdl/sbit_overlap.sv @@
// ----------------------------------------------------------------------------
// Swept box impact time - overlap test
// Exact strict overlap on one axis at time t, three register stages.
// ----------------------------------------------------------------------------
module sbit_overlap #(
  parameter int C = 32,
  parameter int F = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [C:0]  dp_i,
  input  logic signed [C:0]  dv_i,
  input  logic [C-2:0]       sa_i,
  input  logic [C-2:0]       sb_i,
  input  logic [C-1:0]       t_i,
  output logic               ok_o
);

  localparam int H  = C / 2;
  localparam int HL = C - H;
  localparam int W  = 2 * C + F + 3;

  // stage 1: two partial products
  logic signed [C+H+1:0]  pl_q;
  logic signed [C+HL+1:0] ph_q;
  logic signed [C:0]      dp1_q;
  logic [C-2:0]           sa1_q, sb1_q;
  // stage 2: position difference at t
  logic signed [W-1:0]    d2_q;
  logic [C-2:0]           sa2_q, sb2_q;
  // stage 3: compare
  logic                   ok_q;

  logic signed [W-1:0] sum_d;
  logic signed [W-1:0] lo_w, hi_w;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q  <= dv_i * $signed({1'b0, t_i[H-1:0]});
      ph_q  <= dv_i * $signed({1'b0, t_i[C-1:H]});
      dp1_q <= dp_i;
      sa1_q <= sa_i;
      sb1_q <= sb_i;
    end
  end

  assign sum_d = (W'(dp1_q) <<< F) + (W'(ph_q) <<< H) + W'(pl_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d2_q  <= sum_d;
      sa2_q <= sa1_q;
      sb2_q <= sb1_q;
    end
  end

  assign lo_w = -(W'(sa2_q) << F);
  assign hi_w = W'(sb2_q) << F;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok_q <= (lo_w < d2_q) && (d2_q < hi_w);
    end
  end

  assign ok_o = ok_q;

endmodule

@@ hdl/swept_box_impact_time_top.sv @@
// Input word to output word: stage A, divider, overlap test and output registers.
// Throughput: one word per cycle unless the output stalls; the four gap dividers are
//   fully pipelined, one quotient bit per stage, and set the depth.
// A stalled output word freezes the whole pipeline; no word is lost or repeated.
// Reset (rst_ni low, asynchronous) clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
// Swept box impact time - top level
// Earliest contact time and faces of two moving 2D boxes, swept AABB test.
// ----------------------------------------------------------------------------
module swept_box_impact_time_top #(
  parameter int COORD_BITS = sbit_pkg::CoordBits,
  parameter int FRAC_BITS  = sbit_pkg::FracBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] a_pos_x_i,
  input  logic signed [COORD_BITS-1:0] a_pos_y_i,
  input  logic        [COORD_BITS-2:0] a_width_i,
  input  logic        [COORD_BITS-2:0] a_height_i,
  input  logic signed [COORD_BITS-1:0] a_vel_x_i,
  input  logic signed [COORD_BITS-1:0] a_vel_y_i,
  input  logic signed [COORD_BITS-1:0] b_pos_x_i,
  input  logic signed [COORD_BITS-1:0] b_pos_y_i,
  input  logic        [COORD_BITS-2:0] b_width_i,
  input  logic        [COORD_BITS-2:0] b_height_i,
  input  logic signed [COORD_BITS-1:0] b_vel_x_i,
  input  logic signed [COORD_BITS-1:0] b_vel_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic        [COORD_BITS-1:0] impact_time_o,
  output logic        [2:0]            face_a_o,
  output logic        [2:0]            face_b_o
);

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int NC  = sbit_pkg::NumCases;
  localparam int NW  = C + 1;        // |gap| and |dv| magnitude bits
  localparam int QW  = NW + F;       // full quotient bits
  localparam int GW  = C + 2;        // signed gap
  localparam int SW  = NC + 8 * C;   // sideband through the dividers
  localparam int TW  = NC + NC * C;  // sideband through the overlap test
  localparam int OVL = 3;            // overlap test depth
  localparam int L   = 1 + QW + OVL; // stages before the output register

  // one enable for the whole pipe: moves unless a finished word is stuck
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic [L-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[L-2:0], in_valid_i};
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: edges, gaps, relative velocities, case applicability
  // --------------------------------------------------------------------------
  logic signed [GW-1:0] ax_e, ay_e, bx_e, by_e, aw_e, ah_e, bw_e, bh_e;
  logic signed [GW-1:0] gap_d [NC];
  logic signed [C:0]    dvx_d, dvy_d, dpx_d, dpy_d;
  logic [NC-1:0]        cok_d;

  assign ax_e = GW'(a_pos_x_i);
  assign ay_e = GW'(a_pos_y_i);
  assign bx_e = GW'(b_pos_x_i);
  assign by_e = GW'(b_pos_y_i);
  assign aw_e = $signed(GW'(a_width_i));
  assign ah_e = $signed(GW'(a_height_i));
  assign bw_e = $signed(GW'(b_width_i));
  assign bh_e = $signed(GW'(b_height_i));

  assign gap_d[0] = bx_e - (ax_e + aw_e);   // a right -> b left
  assign gap_d[1] = (bx_e + bw_e) - ax_e;   // a left  -> b right
  assign gap_d[2] = by_e - (ay_e + ah_e);   // a up    -> b bottom
  assign gap_d[3] = (by_e + bh_e) - ay_e;   // a down  -> b top

  assign dvx_d = (C+1)'(a_vel_x_i) - (C+1)'(b_vel_x_i);
  assign dvy_d = (C+1)'(a_vel_y_i) - (C+1)'(b_vel_y_i);
  assign dpx_d = (C+1)'(a_pos_x_i) - (C+1)'(b_pos_x_i);
  assign dpy_d = (C+1)'(a_pos_y_i) - (C+1)'(b_pos_y_i);

  // own velocity toward b, strictly separated, closing relative velocity
  assign cok_d[0] = (a_vel_x_i > 0) && (gap_d[0] > 0) && (dvx_d > 0);
  assign cok_d[1] = (a_vel_x_i < 0) && (gap_d[1] < 0) && (dvx_d < 0);
  assign cok_d[2] = (a_vel_y_i > 0) && (gap_d[2] > 0) && (dvy_d > 0);
  assign cok_d[3] = (a_vel_y_i < 0) && (gap_d[3] < 0) && (dvy_d < 0);

  logic signed [GW-1:0] gap_q [NC];
  logic signed [C:0]    dvx_q, dvy_q, dpx_q, dpy_q;
  logic [NC-1:0]        cok_q;
  logic [C-2:0]         aw_q, ah_q, bw_q, bh_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      gap_q <= gap_d;
      dvx_q <= dvx_d;
      dvy_q <= dvy_d;
      dpx_q <= dpx_d;
      dpy_q <= dpy_d;
      cok_q <= cok_d;
      aw_q  <= a_width_i;
      ah_q  <= a_height_i;
      bw_q  <= b_width_i;
      bh_q  <= b_height_i;
    end
  end

  // --------------------------------------------------------------------------
  // Dividers: t = |gap| * 2^F / |dv|, truncated
  // --------------------------------------------------------------------------
  logic [NW-1:0] adv_x, adv_y;
  logic [QW-1:0] quo [NC];

  assign adv_x = dvx_q[C] ? NW'(-dvx_q) : NW'(dvx_q);
  assign adv_y = dvy_q[C] ? NW'(-dvy_q) : NW'(dvy_q);

  for (genvar c = 0; c < NC; c++) begin : g_div
    logic [NW-1:0] agap;
    assign agap = gap_q[c][GW-1] ? NW'(-gap_q[c]) : NW'(gap_q[c]);

    sbit_div #(.NW(NW), .DW(NW), .F(F)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (agap),
      .den_i ((c < 2) ? adv_x : adv_y),
      .quo_o (quo[c])
    );
  end

  // sideband alongside the dividers
  logic [SW-1:0] sb_in, sb_out;
  logic [SW-1:0] sb_q [QW];

  assign sb_in = {cok_q, dpx_q, dpy_q, dvx_q, dvy_q, aw_q, ah_q, bw_q, bh_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= sb_in;
      for (int k = 1; k < QW; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  assign sb_out = sb_q[QW-1];

  logic [NC-1:0]     cok_m;
  logic signed [C:0] dpx_m, dpy_m, dvx_m, dvy_m;
  logic [C-2:0]      aw_m, ah_m, bw_m, bh_m;

  assign {cok_m, dpx_m, dpy_m, dvx_m, dvy_m, aw_m, ah_m, bw_m, bh_m} = sb_out;

  // --------------------------------------------------------------------------
  // Overlap on the other axis at each candidate time
  // --------------------------------------------------------------------------
  logic [NC-1:0] tok_m, ovl_ok;
  logic [C-1:0]  t_m [NC];

  for (genvar c = 0; c < NC; c++) begin : g_ovl
    assign t_m[c]   = quo[c][C-1:0];
    // a quotient above the output range is no hit
    assign tok_m[c] = cok_m[c] && (quo[c][QW-1:C] == '0);

    if (c < 2) begin : g_horiz
      sbit_overlap #(.C(C), .F(F)) u_ovl (
        .clk_i (clk_i), .en_i (en),
        .dp_i  (dpy_m), .dv_i (dvy_m), .sa_i (ah_m), .sb_i (bh_m),
        .t_i   (t_m[c]), .ok_o (ovl_ok[c])
      );
    end else begin : g_vert
      sbit_overlap #(.C(C), .F(F)) u_ovl (
        .clk_i (clk_i), .en_i (en),
        .dp_i  (dpx_m), .dv_i (dvx_m), .sa_i (aw_m), .sb_i (bw_m),
        .t_i   (t_m[c]), .ok_o (ovl_ok[c])
      );
    end
  end

  logic [TW-1:0] tb_q [OVL];
  logic [TW-1:0] tb_in;

  assign tb_in = {tok_m, t_m[0], t_m[1], t_m[2], t_m[3]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      tb_q[0] <= tb_in;
      for (int k = 1; k < OVL; k++) begin
        tb_q[k] <= tb_q[k-1];
      end
    end
  end

  logic [NC-1:0] tok_f;
  logic [C-1:0]  t_f [NC];

  assign {tok_f, t_f[0], t_f[1], t_f[2], t_f[3]} = tb_q[OVL-1];

  // --------------------------------------------------------------------------
  // Pick the earliest case; ties keep the earlier case
  // --------------------------------------------------------------------------
  logic                found_d;
  logic [C-1:0]        best_d;
  sbit_pkg::face_e     fa_d, fb_d;

  always_comb begin
    found_d = 1'b0;
    best_d  = '1;
    fa_d    = sbit_pkg::FaceNone;
    fb_d    = sbit_pkg::FaceNone;
    for (int c = 0; c < NC; c++) begin
      if (tok_f[c] && ovl_ok[c] && (!found_d || (t_f[c] < best_d))) begin
        found_d = 1'b1;
        best_d  = t_f[c];
        fa_d    = sbit_pkg::CaseFaceA[c];
        fb_d    = sbit_pkg::CaseFaceB[c];
      end
    end
  end

  // output register
  logic            out_valid_q;
  logic            hit_q;
  logic [C-1:0]    time_q;
  sbit_pkg::face_e fa_q, fb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[L-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= found_d;
      time_q <= best_d;
      fa_q   <= fa_d;
      fb_q   <= fb_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign impact_time_o = time_q;
  assign face_a_o      = fa_q;
  assign face_b_o      = fb_q;

endmodule

@@ hdl/sbit_checker.sv @@
// ----------------------------------------------------------------------------
// Swept box impact time - port checker
// Watches the top level's ports; bound to every instance of it.
// ----------------------------------------------------------------------------
`include "swept_box_impact_time_top_macros.svh"

module sbit_checker #(
  parameter int COORD_BITS = sbit_pkg::CoordBits
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  hit_o,
  input logic [COORD_BITS-1:0] impact_time_o,
  input logic [2:0]            face_a_o,
  input logic [2:0]            face_b_o
);

  // stalled output word holds
  `SBIT_ASSERT(a_out_hold,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(impact_time_o) && $stable(hit_o),
    "output word changed while stalled")
  // a stuck output word stops intake
  `SBIT_ASSERT(a_stall_in, out_valid_o && !out_ready_i |-> !in_ready_o,
    "input taken while output stalled")
  // no hit: all-ones time, no faces
  `SBIT_ASSERT_OUT(a_miss_fmt,
    hit_o || (impact_time_o == '1 && face_a_o == sbit_pkg::FaceNone &&
              face_b_o == sbit_pkg::FaceNone),
    "bad no-hit word")
  // hit: both faces set and different
  `SBIT_ASSERT_OUT(a_hit_face,
    !hit_o || (face_a_o != sbit_pkg::FaceNone && face_b_o != sbit_pkg::FaceNone &&
               face_a_o != face_b_o),
    "bad hit faces")

endmodule

bind swept_box_impact_time_top sbit_checker #(.COORD_BITS(COORD_BITS)) u_sbit_checker (.*);

@@ verif/swept_box_impact_time_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept box impact time - checker
// Watches the input and output channels, computes the expected contact word
// for every accepted box pair and compares it with the block's output.
// ----------------------------------------------------------------------------
module swept_box_impact_time_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] a_pos_x_i,
  input  logic signed [31:0] a_pos_y_i,
  input  logic        [30:0] a_width_i,
  input  logic        [30:0] a_height_i,
  input  logic signed [31:0] a_vel_x_i,
  input  logic signed [31:0] a_vel_y_i,
  input  logic signed [31:0] b_pos_x_i,
  input  logic signed [31:0] b_pos_y_i,
  input  logic        [30:0] b_width_i,
  input  logic        [30:0] b_height_i,
  input  logic signed [31:0] b_vel_x_i,
  input  logic signed [31:0] b_vel_y_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               hit_i,
  input  logic        [31:0] impact_time_i,
  input  logic        [2:0]  face_a_i,
  input  logic        [2:0]  face_b_i,
  output int                 fail_cnt_o,
  output int                 pending_o
);

  typedef struct packed {
    logic            hit;
    logic [31:0]     itime;
    sbit_pkg::face_e fa;
    sbit_pkg::face_e fb;
  } contact_t;

  contact_t contact_q[$];
  int       err_cnt;

  assign fail_cnt_o = err_cnt;
  assign pending_o  = contact_q.size();

  // gap / dv as truncated Q16.16; false when negative, infinite or too big
  function automatic bit sweep_time(longint gap, longint dv, output logic [31:0] t);
    logic [127:0] q;
    longint       n, d;
    t = '0;
    if (dv == 0 || ((gap < 0) != (dv < 0))) return 0;
    n = gap < 0 ? -gap : gap;
    d = dv < 0 ? -dv : dv;
    q = ({64'd0, n} << sbit_pkg::FracBits) / d;
    if (q > 128'hFFFF_FFFF) return 0;
    t = q[31:0];
    return 1;
  endfunction

  // strict overlap on the cross axis at time t, all scaled by 2^16 (16 fractional bits)
  function automatic bit cross_overlap(longint pa, longint pb, longint sa, longint sb,
                                       longint va, longint vb, logic [31:0] t);
    logic signed [127:0] d, lo, hi;
    d  = (128'(signed'(pa - pb)) <<< sbit_pkg::FracBits) +
         128'(signed'(va - vb)) * $signed({96'd0, t});
    lo = -(128'(signed'(sa)) <<< sbit_pkg::FracBits);
    hi = 128'(signed'(sb)) <<< sbit_pkg::FracBits;
    return (lo < d) && (d < hi);
  endfunction

  function automatic contact_t predict_contact();
    contact_t    r;
    longint      ax, ay, aw, ah, avx, avy, bx, by, bw, bh, bvx, bvy;
    longint      gap, dv;
    logic [31:0] t;
    bit          apply, horiz, ok;
    ax = a_pos_x_i; ay = a_pos_y_i; aw = a_width_i; ah = a_height_i;
    avx = a_vel_x_i; avy = a_vel_y_i;
    bx = b_pos_x_i; by = b_pos_y_i; bw = b_width_i; bh = b_height_i;
    bvx = b_vel_x_i; bvy = b_vel_y_i;
    r = '{hit: 1'b0, itime: '1, fa: sbit_pkg::FaceNone, fb: sbit_pkg::FaceNone};
    for (int c = 0; c < sbit_pkg::NumCases; c++) begin
      horiz = c < 2;
      case (c)
        0: begin apply = avx > 0 && ax + aw < bx; gap = bx - (ax + aw); end
        1: begin apply = avx < 0 && ax > bx + bw; gap = bx + bw - ax; end
        2: begin apply = avy > 0 && ay + ah < by; gap = by - (ay + ah); end
        default: begin apply = avy < 0 && ay > by + bh; gap = by + bh - ay; end
      endcase
      if (!apply) continue;
      dv = horiz ? avx - bvx : avy - bvy;
      if (!sweep_time(gap, dv, t)) continue;
      if (r.hit && !(t < r.itime)) continue;
      ok = horiz ? cross_overlap(ay, by, ah, bh, avy, bvy, t)
                 : cross_overlap(ax, bx, aw, bw, avx, bvx, t);
      if (!ok) continue;
      r.hit = 1'b1;
      r.itime = t;
      r.fa = sbit_pkg::CaseFaceA[c];
      r.fb = sbit_pkg::CaseFaceB[c];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    contact_t e;
    if (!rst_ni) begin
      err_cnt <= 0;
    end else begin
      if (in_valid_i && in_ready_i) contact_q.push_back(predict_contact());
      if (out_valid_i && out_ready_i) begin
        if (contact_q.size() == 0) begin
          err_cnt <= err_cnt + 1;
          if (err_cnt < 10) $display("unexpected output word at %0t", $realtime);
        end else begin
          e = contact_q.pop_front();
          if (hit_i !== e.hit || impact_time_i !== e.itime ||
              face_a_i !== e.fa || face_b_i !== e.fb) begin
            err_cnt <= err_cnt + 1;
            if (err_cnt < 10)
              $display("mismatch: exp hit %0d t %h fa %0d fb %0d, got %0d %h %0d %0d",
                       e.hit, e.itime, e.fa, e.fb,
                       hit_i, impact_time_i, face_a_i, face_b_i);
          end
        end
      end
    end
  end

endmodule

@@ verif/tb_swept_box_impact_time_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept box impact time - testbench top
// Drives box pairs with bursty valid and a stalling receiver; the checker
// beside the block predicts each contact word and counts mismatches.
// ----------------------------------------------------------------------------
module tb_swept_box_impact_time_top;

  localparam int NumRandom = 500;
  localparam int Latency   = 54;
  localparam int CycleCap  = 400000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [31:0] a_pos_x_i, a_pos_y_i, a_vel_x_i, a_vel_y_i;
  logic signed [31:0] b_pos_x_i, b_pos_y_i, b_vel_x_i, b_vel_y_i;
  logic [30:0] a_width_i, a_height_i, b_width_i, b_height_i;
  logic        hit_o;
  logic [31:0] impact_time_o;
  logic [2:0]  face_a_o, face_b_o;
  int          fail_cnt, pending;
  int          cycle_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  swept_box_impact_time_top u_top (.*);

  swept_box_impact_time_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .a_pos_x_i, .a_pos_y_i, .a_width_i, .a_height_i, .a_vel_x_i, .a_vel_y_i,
    .b_pos_x_i, .b_pos_y_i, .b_width_i, .b_height_i, .b_vel_x_i, .b_vel_y_i,
    .out_valid_i(out_valid_o), .out_ready_i, .hit_i(hit_o),
    .impact_time_i(impact_time_o), .face_a_i(face_a_o), .face_b_i(face_b_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // watchdog: a hung pipeline ends the run as a failure
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleCap) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver stalls: alternating runs of ready and stall, some long open runs
  initial begin
    int run;
    out_ready_i = 1'b0;
    forever begin
      run = $urandom_range(1, 12);
      repeat (run) @(negedge clk_i) out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) != 0) begin
        run = $urandom_range(1, 8);
        repeat (run) @(negedge clk_i) out_ready_i <= 1'b0;
      end
    end
  end

  // random 32-bit value: full range, small values or corner words
  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'(signed'($urandom_range(0, 400 << 16)) - (200 << 16));
    endcase
  endfunction

  // one word; sender holds it until accepted
  task automatic send_word(input logic [31:0] ax, ay, aw, ah, avx, avy,
                           bx, by, bw, bh, bvx, bvy);
    a_pos_x_i <= ax; a_pos_y_i <= ay; a_width_i <= aw[30:0]; a_height_i <= ah[30:0];
    a_vel_x_i <= avx; a_vel_y_i <= avy;
    b_pos_x_i <= bx; b_pos_y_i <= by; b_width_i <= bw[30:0]; b_height_i <= bh[30:0];
    b_vel_x_i <= bvx; b_vel_y_i <= bvy;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // well-formed approach along one axis, with random overlap on the other
  task automatic send_approach();
    logic [31:0] p[12];
    int dir;
    dir = $urandom_range(0, 3);
    foreach (p[i]) p[i] = 32'(signed'($urandom_range(0, 64 << 16)) - (32 << 16));
    p[2] = $urandom_range(1, 16 << 16); p[3] = $urandom_range(1, 16 << 16);
    p[8] = $urandom_range(1, 16 << 16); p[9] = $urandom_range(1, 16 << 16);
    p[4] = 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
    p[5] = 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
    p[10] = $urandom_range(0, 3) == 0 ? 32'd0 : 32'(signed'($urandom_range(0, 1 << 16)) - 32768);
    p[11] = $urandom_range(0, 3) == 0 ? 32'd0 : 32'(signed'($urandom_range(0, 1 << 16)) - 32768);
    case (dir)
      0: begin p[4] = $urandom_range(1, 8 << 16); p[6] = p[0] + p[2] + $urandom_range(1, 40 << 16); end
      1: begin p[4] = -$urandom_range(1, 8 << 16); p[0] = p[6] + p[8] + $urandom_range(1, 40 << 16); end
      2: begin p[5] = $urandom_range(1, 8 << 16); p[7] = p[1] + p[3] + $urandom_range(1, 40 << 16); end
      default: begin p[5] = -$urandom_range(1, 8 << 16); p[1] = p[7] + p[9] + $urandom_range(1, 40 << 16); end
    endcase
    // align boxes on the cross axis most of the time
    if ($urandom_range(0, 3) != 0) begin
      if (dir < 2) p[7] = p[1] + 32'(signed'($urandom_range(0, 2 << 16)) - (1 << 16));
      else         p[6] = p[0] + 32'(signed'($urandom_range(0, 2 << 16)) - (1 << 16));
    end
    send_word(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8], p[9], p[10], p[11]);
  endtask

  initial begin
    logic [31:0] w[12];
    int gap;
    in_valid_i = 1'b0;
    {a_pos_x_i, a_pos_y_i, a_vel_x_i, a_vel_y_i} = '0;
    {b_pos_x_i, b_pos_y_i, b_vel_x_i, b_vel_y_i} = '0;
    {a_width_i, a_height_i, b_width_i, b_height_i} = '0;
    rst_ni = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: right, left, up, down hits, zero relative velocity,
    // receding, tie between axes, zero time, quotient overflow, extremes
    send_word(0, 0, 32'h10000, 32'h10000, 32'h10000, 0, 32'h30000, 0, 32'h10000, 32'h10000, 0, 0);
    send_word(32'h30000, 0, 32'h10000, 32'h10000, -32'h10000, 0, 0, 0, 32'h10000, 32'h10000, 0, 0);
    send_word(0, 0, 32'h10000, 32'h10000, 0, 32'h10000, 0, 32'h30000, 32'h10000, 32'h10000, 0, 0);
    send_word(0, 32'h30000, 32'h10000, 32'h10000, 0, -32'h10000, 0, 0, 32'h10000, 32'h10000, 0, 0);
    send_word(0, 0, 32'h10000, 32'h10000, 32'h10000, 0, 32'h30000, 0, 32'h10000, 32'h10000, 32'h10000, 0);
    send_word(0, 0, 32'h10000, 32'h10000, 32'h10000, 0, 32'h30000, 0, 32'h10000, 32'h10000, 32'h20000, 0);
    send_word(0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h30000, 32'h30000,
              32'h10000, 32'h10000, 0, 0);
    send_word(0, 0, 32'h10000, 32'h10000, 32'h7FFFFFFF, 0, 32'h10001, 0, 32'h10000, 32'h10000, 0, 0);
    send_word(32'h80000000, 0, 32'h10000, 32'h10000, 1, 0, 32'h7FFFFFFF, 0, 32'h10000, 32'h10000, 0, 0);
    send_word(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000);
    send_word(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_word('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
    send_word('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1);
    // touching on the cross axis only at edge: no strict overlap
    send_word(0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 0, 32'h30000, 0,
              32'h10000, 32'h10000, 0, 0);

    for (int n = 0; n < NumRandom; n++) begin
      if ($urandom_range(0, 9) < 7) send_approach();
      else begin
        foreach (w[i]) w[i] = rnd_word();
        send_word(w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8], w[9], w[10], w[11]);
      end
      // burst boundary: random gap
      if ($urandom_range(0, 7) == 0) begin
        in_valid_i <= 1'b0;
        gap = $urandom_range(1, 10);
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
    if (fail_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
